FILE: hdl/uarttx_pkg.sv
// Shared types and constants for the UART transmitter with RTS flow control.
// Used by uarttx_core and uart_transmitter_with_rts_unit; depends on nothing.
package uarttx_pkg;

  // Configuration register indexes on the write port
  localparam logic [2:0] REG_DATA_BITS   = 3'd0;
  localparam logic [2:0] REG_PARITY_MODE = 3'd1;
  localparam logic [2:0] REG_STOP_BITS   = 3'd2;
  localparam logic [2:0] REG_LSB_FIRST   = 3'd3;
  localparam logic [2:0] REG_BIT_CLKS    = 3'd4;
  localparam logic [2:0] REG_GAP_CLKS    = 3'd5;
  localparam logic [2:0] REG_RTS_MODE    = 3'd6;
  localparam logic [2:0] REG_RTS_TIMEOUT = 3'd7;

  // Parity and RTS mode codes
  localparam logic [1:0] PARITY_NONE = 2'd0;
  localparam logic [1:0] PARITY_EVEN = 2'd1;
  localparam logic [1:0] PARITY_ODD  = 2'd2;
  localparam logic [1:0] RTS_IGNORE  = 2'd0;
  localparam logic [1:0] RTS_HIGH    = 2'd1;
  localparam logic [1:0] RTS_LOW     = 2'd2;

  typedef struct packed {
    logic [3:0]  char_bits;
    logic [1:0]  parity_mode;
    logic [1:0]  stop_count;
    logic        lsb_leads;
    logic [15:0] bit_ticks;
    logic [15:0] gap_clks;
    logic [1:0]  rts_mode;
    logic [15:0] rts_timeout_clks;
  } cfg_t;

  typedef struct packed {
    logic       frame_valid;
    logic [8:0] frame_data;
    logic       bad_parity;
    logic       bad_stop;
    logic [7:0] frame_ticket;
    logic       rts_level;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic       frame_taken;
    logic       busy_res;
    logic       frame_done;
    logic [7:0] done_ticket;
    logic       rts_timeout;
  } out_item_t;

endpackage

FILE: hdl/uarttx_core.sv
// Bit-timing state machine of the UART transmitter: one tick per transaction.
// Depends on uarttx_pkg for the configuration, tick and result types.
module uarttx_core #(
  parameter int POLL_CLKS = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  uarttx_pkg::cfg_t      cfg,
  input  uarttx_pkg::in_item_t  item,
  output uarttx_pkg::out_item_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HOLD, PH_START, PH_DATA, PH_PARITY, PH_STOP, PH_GAP
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] bit_timer, bit_timer_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [8:0]  held_data, held_data_next;
  logic [7:0]  held_ticket, held_ticket_next;
  logic [1:0]  held_faults, held_faults_next;
  logic [15:0] rts_wait_count, rts_wait_count_next;
  logic [15:0] gap_count, gap_count_next;
  logic        line_level, line_level_next;

  logic [3:0]  eff_bits;
  logic        two_stops;
  logic        parity_on;
  logic        rts_active;
  logic [15:0] bit_load;
  logic [3:0]  count_inc;
  logic [16:0] wait_sum;
  logic [15:0] gap_dec;
  logic        taken, done, tmo;

  // Pick one data bit of the held word for the given bit position
  function automatic logic data_bit(input logic [8:0] data, input logic [3:0] cnt,
                                    input logic [3:0] n, input logic lsb);
    logic [4:0] src;
    begin
      src = lsb ? {1'b0, cnt} : 5'({1'b0, n} - 5'd1 - {1'b0, cnt});
      if (src > 5'd8) begin
        data_bit = data[0];
      end else begin
        data_bit = data[src[3:0]];
      end
    end
  endfunction

  // Parity of the low n data bits, flipped for odd mode and forced faults
  function automatic logic parity_of(input logic [8:0] data, input logic [3:0] n,
                                     input logic odd, input logic force_bad);
    logic p;
    begin
      p = odd ^ force_bad;
      for (int i = 0; i < 9; i++) begin
        if (4'(i) < n) begin
          p = p ^ data[i];
        end
      end
      parity_of = p;
    end
  endfunction

  // Clamp out-of-range registers to their working values
  always_comb begin
    if (cfg.char_bits < 4'd5) begin
      eff_bits = 4'd5;
    end else if (cfg.char_bits > 4'd9) begin
      eff_bits = 4'd9;
    end else begin
      eff_bits = cfg.char_bits;
    end
    two_stops = cfg.stop_count[1];
    parity_on = (cfg.parity_mode == uarttx_pkg::PARITY_EVEN) ||
                (cfg.parity_mode == uarttx_pkg::PARITY_ODD);
    case (cfg.rts_mode)
      uarttx_pkg::RTS_HIGH: rts_active = item.rts_level;
      uarttx_pkg::RTS_LOW:  rts_active = !item.rts_level;
      default:              rts_active = 1'b1;
    endcase
    bit_load  = (cfg.bit_ticks == 16'd0) ? 16'd0 : cfg.bit_ticks - 16'd1;
    count_inc = bit_count + 4'd1;
    wait_sum  = {1'b0, rts_wait_count} + 17'(POLL_CLKS);
    gap_dec   = (gap_count != 16'd0) ? gap_count - 16'd1 : 16'd0;
  end

  // Next state and result of one tick
  always_comb begin
    phase_next          = phase;
    bit_timer_next      = bit_timer;
    bit_count_next      = bit_count;
    held_data_next      = held_data;
    held_ticket_next    = held_ticket;
    held_faults_next    = held_faults;
    rts_wait_count_next = rts_wait_count;
    gap_count_next      = gap_count;
    line_level_next     = line_level;
    taken               = 1'b0;
    done                = 1'b0;
    tmo                 = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        line_level_next = 1'b1;
        if (item.frame_valid) begin
          held_data_next      = item.frame_data;
          held_ticket_next    = item.frame_ticket;
          held_faults_next    = {item.bad_stop, item.bad_parity};
          rts_wait_count_next = 16'd0;
          bit_timer_next      = 16'd0;
          phase_next          = PH_HOLD;
          taken               = 1'b1;
        end
      end
      PH_HOLD: begin
        if (bit_timer != 16'd0) begin
          bit_timer_next = bit_timer - 16'd1;
        end else if (rts_active) begin
          phase_next      = PH_START;
          line_level_next = 1'b0;
          bit_timer_next  = bit_load;
        end else if (cfg.rts_timeout_clks != 16'd0 &&
                     rts_wait_count >= cfg.rts_timeout_clks) begin
          tmo                 = 1'b1;
          rts_wait_count_next = 16'd0;
          bit_timer_next      = 16'(POLL_CLKS - 1);
        end else begin
          rts_wait_count_next = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
          bit_timer_next      = 16'(POLL_CLKS - 1);
        end
      end
      PH_START, PH_DATA, PH_PARITY, PH_STOP: begin
        if (bit_timer != 16'd0) begin
          bit_timer_next = bit_timer - 16'd1;
        end else if (phase == PH_START) begin
          phase_next      = PH_DATA;
          bit_count_next  = 4'd0;
          line_level_next = data_bit(held_data, 4'd0, eff_bits, cfg.lsb_leads);
          bit_timer_next  = bit_load;
        end else if (phase == PH_DATA) begin
          bit_count_next = count_inc;
          bit_timer_next = bit_load;
          if (count_inc < eff_bits) begin
            line_level_next = data_bit(held_data, count_inc, eff_bits, cfg.lsb_leads);
          end else if (parity_on) begin
            phase_next      = PH_PARITY;
            line_level_next = parity_of(held_data, eff_bits,
                                        cfg.parity_mode == uarttx_pkg::PARITY_ODD,
                                        held_faults[0]);
          end else begin
            phase_next      = PH_STOP;
            bit_count_next  = 4'd0;
            line_level_next = !held_faults[1];
          end
        end else if (phase == PH_PARITY) begin
          phase_next      = PH_STOP;
          bit_count_next  = 4'd0;
          line_level_next = !held_faults[1];
          bit_timer_next  = bit_load;
        end else if (count_inc < (two_stops ? 4'd2 : 4'd1)) begin
          bit_count_next  = count_inc;
          line_level_next = !held_faults[1];
          bit_timer_next  = bit_load;
        end else begin
          // Last stop bit finished: report and go to gap or idle
          line_level_next = 1'b1;
          bit_timer_next  = 16'd0;
          bit_count_next  = 4'd0;
          done            = 1'b1;
          if (cfg.gap_clks != 16'd0) begin
            phase_next     = PH_GAP;
            gap_count_next = cfg.gap_clks;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_GAP: begin
        line_level_next = 1'b1;
        gap_count_next  = gap_dec;
        if (gap_dec == 16'd0) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        line_level_next = 1'b1;
      end
    endcase

    res.tx_line     = line_level_next;
    res.frame_taken = taken;
    res.busy_res    = (phase_next != PH_IDLE);
    res.frame_done  = done;
    res.done_ticket = done ? held_ticket : 8'd0;
    res.rts_timeout = tmo;
  end

  // Hold state; advance one tick per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_timer      <= 16'd0;
      bit_count      <= 4'd0;
      rts_wait_count <= 16'd0;
      gap_count      <= 16'd0;
      line_level     <= 1'b1;
    end else if (advance) begin
      phase          <= phase_next;
      bit_timer      <= bit_timer_next;
      bit_count      <= bit_count_next;
      rts_wait_count <= rts_wait_count_next;
      gap_count      <= gap_count_next;
      line_level     <= line_level_next;
    end
  end

  // Frame payload needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      held_data   <= held_data_next;
      held_ticket <= held_ticket_next;
      held_faults <= held_faults_next;
    end
  end

endmodule

FILE: hdl/uart_transmitter_with_rts_unit.sv
// UART transmitter with RTS flow control: one input transaction is one line tick.
// The result of an accepted tick is loaded into the output register, out_data.
// Throughput: one tick per cycle; the single output register sets it and the input
// is taken while that register is empty or being drained.
// Reset (rst, synchronous): idle phase, line high, output empty, registers at defaults.
// Depends on uarttx_pkg and uarttx_core.
module uart_transmitter_with_rts_unit #(
  parameter int POLL_CLKS = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  uarttx_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output uarttx_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  uarttx_pkg::cfg_t      cfg;
  uarttx_pkg::out_item_t res;
  logic                  accept;

  // Take a tick whenever the output register is free or draining
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_bits        <= 4'd8;
      cfg.parity_mode      <= uarttx_pkg::PARITY_NONE;
      cfg.stop_count       <= 2'd1;
      cfg.lsb_leads        <= 1'b1;
      cfg.bit_ticks        <= 16'd16;
      cfg.gap_clks         <= 16'd0;
      cfg.rts_mode         <= uarttx_pkg::RTS_IGNORE;
      cfg.rts_timeout_clks <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uarttx_pkg::REG_DATA_BITS:   cfg.char_bits        <= cfg_data[3:0];
        uarttx_pkg::REG_PARITY_MODE: cfg.parity_mode      <= cfg_data[1:0];
        uarttx_pkg::REG_STOP_BITS:   cfg.stop_count       <= cfg_data[1:0];
        uarttx_pkg::REG_LSB_FIRST:   cfg.lsb_leads        <= cfg_data[0];
        uarttx_pkg::REG_BIT_CLKS:    cfg.bit_ticks        <= cfg_data;
        uarttx_pkg::REG_GAP_CLKS:    cfg.gap_clks         <= cfg_data;
        uarttx_pkg::REG_RTS_MODE:    cfg.rts_mode         <= cfg_data[1:0];
        uarttx_pkg::REG_RTS_TIMEOUT: cfg.rts_timeout_clks <= cfg_data;
        default: ;
      endcase
    end
  end

  uarttx_core #(
    .POLL_CLKS(POLL_CLKS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .cfg    (cfg),
    .item   (in_data),
    .res    (res)
  );

  // Output register: load on a new tick, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");

  a_taken_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_taken) |-> (out_data.busy_res && out_data.tx_line))
    else $error("taken frame must leave the line high and the unit busy");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_done) |->
      (out_data.tx_line && !out_data.frame_taken && !out_data.rts_timeout))
    else $error("frame completion with inconsistent line or flags");

  a_ticket_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.frame_done) |-> (out_data.done_ticket == 8'd0))
    else $error("ticket reported without completion");
`endif

endmodule

FILE: bench/uart_transmitter_with_rts_unit_test.sv
// Self-checking bench for uart_transmitter_with_rts_unit: a short table of line ticks,
// then randomized frames under changing settings; each result is checked against a table entry or a tick model.
// Depends on uarttx_pkg and the RTL under hdl/.
module uart_transmitter_with_rts_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POLL = 1;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    LINE_IDLE, LINE_HOLD, LINE_START, LINE_DATA, LINE_PARITY, LINE_STOP, LINE_GAP
  } line_state_t;

  // One row of the directed table; ticks of zero runs until the line is idle again
  typedef struct packed {
    logic                  set_cfg;
    uarttx_pkg::cfg_t      cfg;
    uarttx_pkg::in_item_t  item;
    logic [19:0]           ticks;
    logic                  typed;
    uarttx_pkg::out_item_t want;
  } drill_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  uarttx_pkg::in_item_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  uarttx_pkg::out_item_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  int unsigned tx_idle_pct = 18;
  int unsigned rx_stall_pct = 72;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  uarttx_pkg::out_item_t line_exp [$];

  // Tick model state and its copy of the settings
  line_state_t line_ph = LINE_IDLE;
  logic [15:0] tick_left = '0;
  logic [3:0]  bits_sent = '0;
  logic [8:0]  held_word = '0;
  logic [7:0]  held_id = '0;
  logic [1:0]  held_flt = '0;
  int unsigned wait_ticks = 0;
  logic [15:0] gap_left = '0;
  logic        line_lvl = 1'b1;
  uarttx_pkg::cfg_t line_cfg = {4'd8, uarttx_pkg::PARITY_NONE, 2'd1, 1'b1, 16'd16, 16'd0,
                                uarttx_pkg::RTS_IGNORE, 16'd0};

  uart_transmitter_with_rts_unit #(.POLL_CLKS(POLL)) uut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < rx_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Effective data bit count, saturated to 5..9
  function automatic int unsigned word_len();
    if (line_cfg.char_bits < 5) return 5;
    if (line_cfg.char_bits > 9) return 9;
    return line_cfg.char_bits;
  endfunction

  // Put a level on the line and load a full bit time
  function automatic void hold_level(logic lvl);
    line_lvl = lvl;
    tick_left = (line_cfg.bit_ticks == 0) ? 16'd0 : line_cfg.bit_ticks - 16'd1;
  endfunction

  function automatic void drive_data();
    int src;
    if (line_cfg.lsb_leads) src = int'(bits_sent);
    else src = int'(word_len()) - 1 - int'(bits_sent);
    if (src < 0 || src > 8) src = 0;
    hold_level(held_word[src]);
  endfunction

  // Advance the line by one tick and return what the block reports for it
  function automatic uarttx_pkg::out_item_t advance_line(uarttx_pkg::in_item_t it);
    uarttx_pkg::out_item_t r;
    logic go;
    logic [8:0] mask;
    logic par;
    r = '0;
    case (line_ph)
      LINE_IDLE: begin
        line_lvl = 1'b1;
        if (it.frame_valid) begin
          held_word = it.frame_data;
          held_id = it.frame_ticket;
          held_flt = {it.bad_stop, it.bad_parity};
          wait_ticks = 0;
          tick_left = '0;
          line_ph = LINE_HOLD;
          r.frame_taken = 1'b1;
        end
      end
      LINE_HOLD: begin
        if (tick_left != 0) begin
          tick_left--;
        end else begin
          go = 1'b1;
          if (line_cfg.rts_mode == uarttx_pkg::RTS_HIGH) go = it.rts_level;
          else if (line_cfg.rts_mode == uarttx_pkg::RTS_LOW) go = !it.rts_level;
          if (go) begin
            line_ph = LINE_START;
            hold_level(1'b0);
          end else begin
            if (line_cfg.rts_timeout_clks != 0 && wait_ticks >= line_cfg.rts_timeout_clks) begin
              r.rts_timeout = 1'b1;
              wait_ticks = 0;
            end else begin
              wait_ticks = (wait_ticks + POLL > 65535) ? 65535 : wait_ticks + POLL;
            end
            tick_left = 16'(POLL - 1);
          end
        end
      end
      LINE_START, LINE_DATA, LINE_PARITY, LINE_STOP: begin
        if (tick_left != 0) begin
          tick_left--;
        end else if (line_ph == LINE_START) begin
          line_ph = LINE_DATA;
          bits_sent = '0;
          drive_data();
        end else if (line_ph == LINE_DATA) begin
          bits_sent++;
          if (bits_sent < word_len()) begin
            drive_data();
          end else if (line_cfg.parity_mode == uarttx_pkg::PARITY_EVEN ||
                       line_cfg.parity_mode == uarttx_pkg::PARITY_ODD) begin
            mask = 9'h1FF >> (9 - word_len());
            par = ^(held_word & mask) ^ (line_cfg.parity_mode == uarttx_pkg::PARITY_ODD) ^
                  held_flt[0];
            line_ph = LINE_PARITY;
            hold_level(par);
          end else begin
            line_ph = LINE_STOP;
            bits_sent = '0;
            hold_level(!held_flt[1]);
          end
        end else if (line_ph == LINE_PARITY) begin
          line_ph = LINE_STOP;
          bits_sent = '0;
          hold_level(!held_flt[1]);
        end else begin
          bits_sent++;
          if (bits_sent < ((line_cfg.stop_count >= 2) ? 2 : 1)) begin
            hold_level(!held_flt[1]);
          end else begin
            // Last stop bit done: report the ticket, then gap or idle
            line_lvl = 1'b1;
            tick_left = '0;
            bits_sent = '0;
            r.frame_done = 1'b1;
            r.done_ticket = held_id;
            if (line_cfg.gap_clks != 0) begin
              line_ph = LINE_GAP;
              gap_left = line_cfg.gap_clks;
            end else begin
              line_ph = LINE_IDLE;
            end
          end
        end
      end
      LINE_GAP: begin
        line_lvl = 1'b1;
        if (gap_left != 0) gap_left--;
        if (gap_left == 0) line_ph = LINE_IDLE;
      end
      default: begin
        line_ph = LINE_IDLE;
        line_lvl = 1'b1;
      end
    endcase
    r.tx_line = line_lvl;
    r.busy_res = (line_ph != LINE_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    uarttx_pkg::out_item_t wanted;
    if (!rst && out_valid && !out_stall) begin
      if (line_exp.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_data);
        errors++;
      end else begin
        wanted = line_exp[0];
        line_exp.delete(0);
        check_field("tx_line", wanted.tx_line, out_data.tx_line);
        check_field("frame_taken", wanted.frame_taken, out_data.frame_taken);
        check_field("busy_res", wanted.busy_res, out_data.busy_res);
        check_field("frame_done", wanted.frame_done, out_data.frame_done);
        check_field("done_ticket", wanted.done_ticket, out_data.done_ticket);
        check_field("rts_timeout", wanted.rts_timeout, out_data.rts_timeout);
      end
    end
  end

  // Offer one tick, hold it until taken, then record its expected result
  task automatic send_tick(input uarttx_pkg::in_item_t it, input logic typed,
                           input uarttx_pkg::out_item_t want);
    uarttx_pkg::out_item_t got;
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    got = advance_line(it);
    line_exp = {line_exp, (typed ? want : got)};
  endtask

  task automatic tick_until_idle(input uarttx_pkg::in_item_t it);
    do send_tick(it, 1'b0, '0); while (line_ph != LINE_IDLE);
  endtask

  // Called at a falling edge; leaves cfg_valid high for the caller to drop
  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      uarttx_pkg::REG_DATA_BITS:   line_cfg.char_bits = val[3:0];
      uarttx_pkg::REG_PARITY_MODE: line_cfg.parity_mode = val[1:0];
      uarttx_pkg::REG_STOP_BITS:   line_cfg.stop_count = val[1:0];
      uarttx_pkg::REG_LSB_FIRST:   line_cfg.lsb_leads = val[0];
      uarttx_pkg::REG_BIT_CLKS:    line_cfg.bit_ticks = val;
      uarttx_pkg::REG_GAP_CLKS:    line_cfg.gap_clks = val;
      uarttx_pkg::REG_RTS_MODE:    line_cfg.rts_mode = val[1:0];
      uarttx_pkg::REG_RTS_TIMEOUT: line_cfg.rts_timeout_clks = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drain all results, then write every register
  task automatic load_settings(input uarttx_pkg::cfg_t c);
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_exp.size() != 0) @(negedge clk);
    put_reg(uarttx_pkg::REG_DATA_BITS, 16'(c.char_bits));
    put_reg(uarttx_pkg::REG_PARITY_MODE, 16'(c.parity_mode));
    put_reg(uarttx_pkg::REG_STOP_BITS, 16'(c.stop_count));
    put_reg(uarttx_pkg::REG_LSB_FIRST, 16'(c.lsb_leads));
    put_reg(uarttx_pkg::REG_BIT_CLKS, c.bit_ticks);
    put_reg(uarttx_pkg::REG_GAP_CLKS, c.gap_clks);
    put_reg(uarttx_pkg::REG_RTS_MODE, 16'(c.rts_mode));
    put_reg(uarttx_pkg::REG_RTS_TIMEOUT, c.rts_timeout_clks);
    cfg_valid <= 1'b0;
  endtask

  function automatic drill_row_t drill_step(logic set_cfg, uarttx_pkg::cfg_t c,
                                            uarttx_pkg::in_item_t it, int unsigned n,
                                            logic typed, uarttx_pkg::out_item_t want);
    drill_row_t r;
    r.set_cfg = set_cfg;
    r.cfg = c;
    r.item = it;
    r.ticks = 20'(n);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  initial begin
    drill_row_t drill [$];
    uarttx_pkg::cfg_t c;
    uarttx_pkg::in_item_t it;
    logic act;

    // Settings: {char bits, parity, stop count, LSB leads, bit ticks, gap, rts_mode, timeout}
    // Ticks:    {frame_valid, frame_data, bad_parity, bad_stop, ticket, rts_level}
    // Results:  {tx_line, taken, busy, done, done_ticket, rts_timeout}
    // Out of reset: idle line, then take a frame, then start bit on an offer while busy
    drill = {drill, drill_step(1'b0, '0, {1'b0, 9'h000, 1'b0, 1'b0, 8'h00, 1'b0}, 1,
                               1'b1, {1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0})};
    drill = {drill, drill_step(1'b0, '0, {1'b1, 9'h1FF, 1'b0, 1'b0, 8'hFF, 1'b0}, 1,
                               1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0})};
    drill = {drill, drill_step(1'b0, '0, {1'b1, 9'h000, 1'b1, 1'b1, 8'h00, 1'b1}, 1,
                               1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0})};
    drill = {drill, drill_step(1'b0, '0, {1'b0, 9'h000, 1'b0, 1'b0, 8'h00, 1'b0}, 0, 1'b0, '0)};
    // Nine bits, odd parity, two stop bits, with both faults injected
    drill = {drill, drill_step(1'b1, {4'd9, uarttx_pkg::PARITY_ODD, 2'd2, 1'b1, 16'd1, 16'd0,
                               uarttx_pkg::RTS_IGNORE, 16'd0},
                               {1'b1, 9'h1FF, 1'b1, 1'b1, 8'h00, 1'b0}, 0, 1'b0, '0)};
    // Five bits MSB first, even parity, short gap
    drill = {drill, drill_step(1'b1, {4'd5, uarttx_pkg::PARITY_EVEN, 2'd1, 1'b0, 16'd2, 16'd3,
                               uarttx_pkg::RTS_IGNORE, 16'd0},
                               {1'b1, 9'h155, 1'b0, 1'b0, 8'hA5, 1'b0}, 0, 1'b0, '0)};
    // Out-of-range settings: data bits saturate high, parity and RTS codes 3, zero stop/bit
    drill = {drill, drill_step(1'b1, {4'd15, 2'd3, 2'd0, 1'b1, 16'd0, 16'd0, 2'd3, 16'd0},
                               {1'b1, 9'h0AA, 1'b0, 1'b0, 8'h5A, 1'b0}, 0, 1'b0, '0)};
    // Data bits saturate low, stop code 3, RTS active high blocked into timeouts
    drill = {drill, drill_step(1'b1, {4'd0, uarttx_pkg::PARITY_ODD, 2'd3, 1'b0, 16'd1, 16'd0,
                               uarttx_pkg::RTS_HIGH, 16'd4},
                               {1'b1, 9'h013, 1'b0, 1'b0, 8'h3C, 1'b0}, 14, 1'b0, '0)};
    drill = {drill, drill_step(1'b0, '0, {1'b0, 9'h000, 1'b0, 1'b0, 8'h00, 1'b1}, 0, 1'b0, '0)};
    // RTS active low, blocked without a timeout
    drill = {drill, drill_step(1'b1, {4'd8, uarttx_pkg::PARITY_EVEN, 2'd1, 1'b1, 16'd1, 16'd1,
                               uarttx_pkg::RTS_LOW, 16'd0},
                               {1'b1, 9'h0F0, 1'b0, 1'b0, 8'h81, 1'b1}, 30, 1'b0, '0)};
    drill = {drill, drill_step(1'b0, '0, {1'b0, 9'h000, 1'b0, 1'b0, 8'h00, 1'b0}, 0, 1'b0, '0)};
    // Shortest timeout, then a gap after the frame
    drill = {drill, drill_step(1'b1, {4'd7, uarttx_pkg::PARITY_NONE, 2'd2, 1'b1, 16'd3, 16'd16,
                               uarttx_pkg::RTS_HIGH, 16'd1},
                               {1'b1, 9'h07F, 1'b0, 1'b0, 8'h42, 1'b0}, 6, 1'b0, '0)};
    drill = {drill, drill_step(1'b0, '0, {1'b1, 9'h100, 1'b1, 1'b1, 8'h99, 1'b1}, 0, 1'b0, '0)};
    // Largest timing values, line left idle
    drill = {drill, drill_step(1'b1, {4'd9, uarttx_pkg::PARITY_ODD, 2'd2, 1'b0, 16'hFFFF,
                               16'hFFFF, uarttx_pkg::RTS_HIGH, 16'hFFFF},
                               {1'b0, 9'h000, 1'b0, 1'b0, 8'h00, 1'b0}, 4, 1'b0, '0)};
    // Longest timeout: a blocked wait that never fires
    drill = {drill, drill_step(1'b1, {4'd6, uarttx_pkg::PARITY_EVEN, 2'd1, 1'b1, 16'd1, 16'd0,
                               uarttx_pkg::RTS_HIGH, 16'hFFFF},
                               {1'b1, 9'h02A, 1'b0, 1'b0, 8'hC3, 1'b0}, 24, 1'b0, '0)};
    drill = {drill, drill_step(1'b0, '0, {1'b0, 9'h000, 1'b0, 1'b0, 8'h00, 1'b1}, 0, 1'b0, '0)};
    // Parity over the low bits only, with the parity fault
    drill = {drill, drill_step(1'b1, {4'd5, uarttx_pkg::PARITY_ODD, 2'd1, 1'b1, 16'd1, 16'd0,
                               uarttx_pkg::RTS_IGNORE, 16'd0},
                               {1'b1, 9'h1E0, 1'b1, 1'b0, 8'h18, 1'b0}, 0, 1'b0, '0)};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (drill[k]) begin
      if (drill[k].set_cfg) load_settings(drill[k].cfg);
      if (drill[k].ticks == 0) tick_until_idle(drill[k].item);
      else repeat (drill[k].ticks) send_tick(drill[k].item, drill[k].typed, drill[k].want);
    end

    // Random frames under random settings, across three idling mixes
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          tx_idle_pct = 18;
          rx_stall_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_stall_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        c.char_bits = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0))
                                                  : 4'($urandom_range(9, 5));
        c.parity_mode = 2'($urandom_range(3, 0));
        c.stop_count = 2'($urandom_range(3, 0));
        c.lsb_leads = 1'($urandom_range(1, 0));
        c.bit_ticks = ($urandom_range(1, 0) == 1) ? 16'd1 : 16'($urandom_range(3, 0));
        c.gap_clks = ($urandom_range(1, 0) == 1) ? 16'd0 : 16'($urandom_range(4, 1));
        c.rts_mode = 2'($urandom_range(3, 0));
        c.rts_timeout_clks = ($urandom_range(1, 0) == 1) ? 16'd0 : 16'($urandom_range(6, 1));
        load_settings(c);
        for (int n = 0; n < 24; n++) begin
          act = ($urandom_range(99, 0) < 70);
          it.frame_valid = ($urandom_range(99, 0) < 35);
          it.frame_data = 9'($urandom_range(511, 0));
          it.bad_parity = ($urandom_range(99, 0) < 15);
          it.bad_stop = ($urandom_range(99, 0) < 15);
          it.frame_ticket = 8'($urandom_range(255, 0));
          it.rts_level = (c.rts_mode == uarttx_pkg::RTS_LOW) ? !act : act;
          send_tick(it, 1'b0, '0);
        end
        // Let the frame in flight finish with RTS held active
        it = '0;
        it.rts_level = (c.rts_mode != uarttx_pkg::RTS_LOW);
        tick_until_idle(it);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (line_exp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
